// File: rtl/core/vna_pkg.sv
// Shared types, constants and arithmetic helpers for the vertex normal accumulator.
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int EDGE_W = 17;
    localparam int PROD_W = 34;
    localparam int FN_W   = 35;
    localparam int NORM_W = 40;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
    localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

    typedef struct packed {
        logic        [1:0]       command;
        logic        [IDX_W-1:0] index_a;
        logic        [IDX_W-1:0] index_b;
        logic        [IDX_W-1:0] index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } t_out_item;

    // triangle corner select
    typedef enum logic [1:0] {
        CRN_A = 2'd0,
        CRN_B = 2'd1,
        CRN_C = 2'd2
    } t_corner;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    pos_rd;
        t_corner pos_sel;
        logic    cap_p0;
        logic    cap_p1;
        logic    cap_edge;
        logic    mul;
        logic    fn;
        logic    nrm_rd;
        logic    nrm_wr;
        t_corner nrm_sel;
        logic    load_wr;
        logic    clr_wr;
        logic    out_load;
    } t_dp_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       a_ok;
        logic       tri_ok;
        logic       clr_last;
    } t_dp_stat;

    // saturating add of a face normal component onto an accumulator
    function automatic logic signed [NORM_W-1:0] sat_add(
        input logic signed [NORM_W-1:0] acc,
        input logic signed [FN_W-1:0]   inc
    );
        logic [NORM_W:0] s;
        s = {acc[NORM_W-1], acc} + {{(NORM_W+1-FN_W){inc[FN_W-1]}}, inc};
        if (s[NORM_W] != s[NORM_W-1]) begin
            return s[NORM_W] ? NORM_MIN : NORM_MAX;
        end
        return s[NORM_W-1:0];
    endfunction

endpackage

// File: rtl/core/vertex_normal_accumulator.sv
// Top level of the area-weighted vertex normal accumulator.
//
// A transaction is taken at a clock edge where start is high and busy is low.
// After reset the block sweeps the normal store to zero, one entry per cycle,
// and holds busy until every entry is cleared. A read, or a load or triangle
// whose indices are in range, keeps busy high while its states run; the next
// transaction can be accepted in the cycle busy drops. A read delivers its
// normal via the store's read register and the result register, with o_valid
// high for exactly one cycle; the receiver has no way to stall it and must
// take it then. A triangle works around the single read port on each store:
// three position reads, one edge stage, one multiply stage, one subtract
// stage, and a read then a saturating write of the normal store per corner.
module vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  vna_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output vna_pkg::t_out_item o_result
);
    import vna_pkg::*;

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    // sequencer: owns busy and every store access
    vna_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_ctrl  (dp_ctrl)
    );

    // stores, cross product and saturating accumulate
    vna_datapath #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctrl   (dp_ctrl),
        .o_stat   (dp_stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    // a result always traces back to an accepted read
    a_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy, 3) && $past(i_item.command, 3) == CMD_READ))
        else $error("result without a matching read transaction");

    // loads, triangles and unused commands never produce a result
    a_no_result_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command != CMD_READ) |-> ##3 !o_valid)
        else $error("result produced by a non-read transaction");

    // the strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

endmodule

// File: rtl/core/vna_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/vna_ctrl.sv
// Sequencing state machine for load, triangle, read and the post-reset clear.
module vna_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vna_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output vna_pkg::t_dp_ctrl o_ctrl
);
    import vna_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_LOAD  = 16'h0004,
        S_RD0   = 16'h0008,
        S_RD1   = 16'h0010,
        S_TP0   = 16'h0020,
        S_TP1   = 16'h0040,
        S_TP2   = 16'h0080,
        S_TP3   = 16'h0100,
        S_MUL   = 16'h0200,
        S_FN    = 16'h0400,
        S_NWR0  = 16'h0800,
        S_NRD1  = 16'h1000,
        S_NWR1  = 16'h2000,
        S_NRD2  = 16'h4000,
        S_NWR2  = 16'h8000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_dp_ctrl ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        ctrl.pos_sel = CRN_A;
        ctrl.nrm_sel = CRN_A;
        unique case (r_state)
            S_CLEAR: begin
                ctrl.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    ctrl.latch = 1'b1;
                    priority if (i_stat.cmd == CMD_LOAD) begin
                        n_state = i_stat.a_ok ? S_LOAD : S_IDLE;
                    end else if (i_stat.cmd == CMD_TRI) begin
                        n_state = i_stat.tri_ok ? S_TP0 : S_IDLE;
                    end else if (i_stat.cmd == CMD_READ) begin
                        n_state = S_RD0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                ctrl.load_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD0: begin
                ctrl.nrm_rd = 1'b1;
                n_state     = S_RD1;
            end
            S_RD1: begin
                ctrl.out_load = 1'b1;
                n_state       = S_IDLE;
            end
            S_TP0: begin
                ctrl.pos_rd = 1'b1;
                n_state     = S_TP1;
            end
            S_TP1: begin
                ctrl.pos_rd  = 1'b1;
                ctrl.pos_sel = CRN_B;
                ctrl.cap_p0  = 1'b1;
                n_state      = S_TP2;
            end
            S_TP2: begin
                ctrl.pos_rd  = 1'b1;
                ctrl.pos_sel = CRN_C;
                ctrl.cap_p1  = 1'b1;
                n_state      = S_TP3;
            end
            S_TP3: begin
                ctrl.cap_edge = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                ctrl.mul = 1'b1;
                n_state  = S_FN;
            end
            S_FN: begin
                ctrl.fn     = 1'b1;
                ctrl.nrm_rd = 1'b1;
                n_state     = S_NWR0;
            end
            S_NWR0: begin
                ctrl.nrm_wr = 1'b1;
                n_state     = S_NRD1;
            end
            S_NRD1: begin
                ctrl.nrm_rd  = 1'b1;
                ctrl.nrm_sel = CRN_B;
                n_state      = S_NWR1;
            end
            S_NWR1: begin
                ctrl.nrm_wr  = 1'b1;
                ctrl.nrm_sel = CRN_B;
                n_state      = S_NRD2;
            end
            S_NRD2: begin
                ctrl.nrm_rd  = 1'b1;
                ctrl.nrm_sel = CRN_C;
                n_state      = S_NWR2;
            end
            S_NWR2: begin
                ctrl.nrm_wr  = 1'b1;
                ctrl.nrm_sel = CRN_C;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctrl = ctrl;
    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/vna_datapath.sv
// Vertex stores, edge/cross-product pipeline and saturating normal update.
module vna_datapath #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vna_pkg::t_in_item  i_item,
    input  vna_pkg::t_dp_ctrl  i_ctrl,
    output vna_pkg::t_dp_stat  o_stat,
    output vna_pkg::t_out_item o_result,
    output logic               o_valid
);
    import vna_pkg::*;

    localparam int AW = $clog2(VERTEX_COUNT);

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTEX_COUNT);
    endfunction

    t_in_item  r_item;
    logic      r_a_ok;
    logic [AW-1:0] r_clr_addr;
    t_out_item r_result;
    logic      r_valid;

    logic signed [POS_W-1:0]  r_pa   [3];
    logic signed [POS_W-1:0]  r_pb   [3];
    logic signed [EDGE_W-1:0] r_e1   [3];
    logic signed [EDGE_W-1:0] r_e2   [3];
    logic signed [PROD_W-1:0] r_prod [6];
    logic signed [FN_W-1:0]   r_fn   [3];

    logic [3*POS_W-1:0]  pos_rdata;
    logic [3*NORM_W-1:0] nrm_rdata;
    logic [3*NORM_W-1:0] nrm_wdata;
    logic [AW-1:0]       pos_raddr;
    logic [AW-1:0]       nrm_addr;
    logic [AW-1:0]       nrm_waddr;
    logic [AW-1:0]       addr_a;
    logic                nrm_we;

    logic signed [POS_W-1:0]  ram_p   [3];
    logic signed [NORM_W-1:0] nrm_cur [3];
    logic signed [NORM_W-1:0] nrm_sum [3];

    // status for the accept decision, straight from the offered item, plus the clear-end flag
    always_comb begin
        o_stat.cmd      = i_item.command;
        o_stat.a_ok     = in_range(i_item.index_a);
        o_stat.tri_ok   = in_range(i_item.index_a) && in_range(i_item.index_b) &&
                          in_range(i_item.index_c);
        o_stat.clr_last = (r_clr_addr == AW'(VERTEX_COUNT - 1));
    end

    function automatic logic [AW-1:0] corner_addr(input t_corner sel, input t_in_item it);
        logic [AW-1:0] a;
        unique case (sel)
            CRN_A:   a = to_addr(it.index_a);
            CRN_B:   a = to_addr(it.index_b);
            CRN_C:   a = to_addr(it.index_c);
            default: a = to_addr(it.index_a);
        endcase
        return a;
    endfunction

    assign addr_a    = to_addr(r_item.index_a);
    assign pos_raddr = corner_addr(i_ctrl.pos_sel, r_item);
    assign nrm_addr  = corner_addr(i_ctrl.nrm_sel, r_item);
    assign nrm_we    = i_ctrl.load_wr || i_ctrl.clr_wr || i_ctrl.nrm_wr;

    always_comb begin
        priority if (i_ctrl.clr_wr) begin
            nrm_waddr = r_clr_addr;
        end else if (i_ctrl.nrm_wr) begin
            nrm_waddr = nrm_addr;
        end else begin
            nrm_waddr = addr_a;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ram_p[k]   = pos_rdata[(3-k)*POS_W-1 -: POS_W];
            nrm_cur[k] = nrm_rdata[(3-k)*NORM_W-1 -: NORM_W];
            nrm_sum[k] = sat_add(nrm_cur[k], r_fn[k]);
        end
    end

    assign nrm_wdata = i_ctrl.nrm_wr ? {nrm_sum[0], nrm_sum[1], nrm_sum[2]} : '0;

    vna_ram #(
        .WIDTH (3*POS_W),
        .DEPTH (VERTEX_COUNT)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.load_wr),
        .i_wr_addr (addr_a),
        .i_wr_data ({r_item.pos_x, r_item.pos_y, r_item.pos_z}),
        .i_rd_en   (i_ctrl.pos_rd),
        .i_rd_addr (pos_raddr),
        .o_rd_data (pos_rdata)
    );

    vna_ram #(
        .WIDTH (3*NORM_W),
        .DEPTH (VERTEX_COUNT)
    ) u_nrm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (nrm_we),
        .i_wr_addr (nrm_waddr),
        .i_wr_data (nrm_wdata),
        .i_rd_en   (i_ctrl.nrm_rd),
        .i_rd_addr (nrm_addr),
        .o_rd_data (nrm_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_ctrl.out_load;
            if (i_ctrl.clr_wr) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_item <= i_item;
            r_a_ok <= in_range(i_item.index_a);
        end
        if (i_ctrl.cap_p0) r_pa <= ram_p;
        if (i_ctrl.cap_p1) r_pb <= ram_p;
        if (i_ctrl.cap_edge) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EDGE_W'(r_pb[k]) - EDGE_W'(r_pa[k]);
                r_e2[k] <= EDGE_W'(ram_p[k]) - EDGE_W'(r_pa[k]);
            end
        end
        if (i_ctrl.mul) begin
            r_prod[0] <= r_e1[1] * r_e2[2];
            r_prod[1] <= r_e1[2] * r_e2[1];
            r_prod[2] <= r_e1[2] * r_e2[0];
            r_prod[3] <= r_e1[0] * r_e2[2];
            r_prod[4] <= r_e1[0] * r_e2[1];
            r_prod[5] <= r_e1[1] * r_e2[0];
        end
        if (i_ctrl.fn) begin
            r_fn[0] <= FN_W'(r_prod[0]) - FN_W'(r_prod[1]);
            r_fn[1] <= FN_W'(r_prod[2]) - FN_W'(r_prod[3]);
            r_fn[2] <= FN_W'(r_prod[4]) - FN_W'(r_prod[5]);
        end
        if (i_ctrl.out_load) begin
            r_result.normal_x <= r_a_ok ? nrm_cur[0] : '0;
            r_result.normal_y <= r_a_ok ? nrm_cur[1] : '0;
            r_result.normal_z <= r_a_ok ? nrm_cur[2] : '0;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule
